FILE: hw/rtl/mandelbrot_escape_time_pixel_defines.svh
// Assertion macros shared by the escape-time pixel RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, held off during reset
`define MBET_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define MBET_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/mbet_pkg.sv
// Package for the escape-time pixel block: sizes, constants, register map,
// controller states and the command/status structs. No dependencies.
package mbet_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 28;

  // Register map
  localparam int ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CENTER_REAL  = 3'd2,
    REG_CENTER_IMAG  = 3'd3,
    REG_PIXEL_STEP   = 3'd4,
    REG_ITER_LIMIT   = 3'd5
  } mbet_reg_t;

  localparam logic [10:0] RST_WIDTH  = 11'd800;
  localparam logic [10:0] RST_HEIGHT = 11'd600;
  localparam logic [15:0] RST_LIMIT  = 16'd256;
  localparam logic [15:0] MIN_LIMIT  = 16'd8;

  // Divider sizing: must hold 4.0 in the fixed-point format
  localparam int DIV_W = (FRAC_BITS + 3 > 32) ? FRAC_BITS + 3 : 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] FOUR_FIX = DIV_W'(4) << FRAC_BITS;
  localparam logic [64:0] FOUR_CMP = 65'(4) << FRAC_BITS;
  localparam logic [30:0] STEP_MAX = 31'h7fff_ffff;

  // Palette constants
  localparam logic [7:0] RED_BASE   = 8'd18;
  localparam logic [7:0] GREEN_BASE = 8'd26;
  localparam logic [7:0] BLUE_BASE  = 8'd70;
  localparam logic [7:0] RED_GAIN   = 8'd220;
  localparam logic [7:0] GREEN_GAIN = 8'd150;
  localparam logic [7:0] BLUE_GAIN  = 8'd175;
  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0] IN_RED     = 8'd8;
  localparam logic [7:0] IN_GREEN   = 8'd10;
  localparam logic [7:0] IN_BLUE    = 8'd16;

  typedef struct packed {
    logic        [10:0] image_width;
    logic        [10:0] image_height;
    logic signed [31:0] center_real;
    logic signed [31:0] center_imag;
    logic        [30:0] pixel_step;
    logic        [15:0] iteration_limit;
  } mbet_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_STEP_WAIT,
    ST_COORD_MUL,
    ST_COORD_ADD,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_PAL_DIV,
    ST_PAL_WAIT,
    ST_PAL_SQ,
    ST_PAL_CUBE,
    ST_OUT_ESC,
    ST_OUT_IN
  } mbet_state_t;

  typedef struct packed {
    logic cap;
    logic div_start;
    logic div_pal;
    logic step_load;
    logic coord_mul;
    logic coord_add;
    logic iter_mul;
    logic iter_upd;
    logic m_load;
    logic pal_sq;
    logic pal_cube;
    logic out_write;
    logic out_inside;
  } mbet_cmd_t;

  typedef struct packed {
    logic step_zero;
    logic div_busy;
    logic div_done;
    logic escape;
    logic last_iter;
    logic out_full;
  } mbet_sts_t;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -65'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/mbet_in_if.sv
// Pixel coordinate channel: valid/ready plus column and row.
// Depends on nothing.
interface mbet_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] column;
  logic [9:0] row;
  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

FILE: hw/rtl/mbet_out_if.sv
// Pixel result channel: valid/ready plus color, count and frame index.
// Depends on nothing.
interface mbet_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] iteration_count;
  logic        inside_set;
  logic [19:0] pixel_index;
  modport source (output valid, output red, output green, output blue, output alpha,
                  output iteration_count, output inside_set, output pixel_index,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input iteration_count, input inside_set, input pixel_index,
                  output ready);
endinterface

FILE: hw/rtl/mbet_divider.sv
// Restoring divider, one quotient bit per cycle while busy, DIV_W quotient bits per divide.
// Depends on mbet_pkg.
module mbet_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mbet_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      busy,
  output logic                      done,
  output logic [mbet_pkg::DIV_W-1:0] quotient
);
  import mbet_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [15:0]          dvs_r, dvs_nxt;
  logic [16:0]          trial;
  logic                 qbit;

  // One shift-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
      quo_nxt = {quo_r[DIV_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/mbet_datapath.sv
// Datapath: point setup, z iteration, palette and the output register.
// Depends on mbet_pkg, mbet_out_if and mbet_divider.
module mbet_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mbet_pkg::mbet_cfg_t   cfg,
  input  logic [9:0]            in_column,
  input  logic [9:0]            in_row,
  input  mbet_pkg::mbet_cmd_t   cmd,
  output mbet_pkg::mbet_sts_t   sts,
  mbet_out_if.source            out_ch
);
  import mbet_pkg::*;

  logic        [9:0]  col_r, row_r;
  logic        [10:0] w_r, h_r, w_nxt, h_nxt;
  logic        [15:0] lim_r, lim_nxt;
  logic        [30:0] step_r;
  logic signed [44:0] prodr_r, prodi_r, prodr_nxt, prodi_nxt;
  logic        [19:0] pidx_r;
  logic        [20:0] pidx_full;
  logic signed [31:0] cr_r, ci_r, zr_r, zi_r, zr_nxt, zi_nxt;
  logic signed [63:0] rr_r, ii_r, ri_r, rr_nxt, ii_nxt, ri_nxt;
  logic        [15:0] iter_r;
  logic        [15:0] m_r;
  logic        [31:0] mm_r;
  logic        [47:0] m3_r;
  logic signed [12:0] offr, offi;
  logic signed [31:0] step_s;
  logic        [64:0] mag;
  logic signed [63:0] diff;
  logic        [39:0] red_t;
  logic        [23:0] green_t;
  logic        [16:0] blue_m;
  logic        [24:0] blue_t;
  logic        [7:0]  red_v, green_v, blue_v;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [15:0]        div_divisor;
  logic               div_busy, div_done;
  logic               out_valid_r;
  logic [7:0]         red_r, green_r, blue_r;
  logic [15:0]        cnt_r;
  logic               inside_r;
  logic [19:0]        pix_out_r;

  // Size and limit clamping at capture
  always_comb begin
    w_nxt = cfg.image_width;
    if (w_nxt == '0) w_nxt = 11'd1;
    else if (32'(w_nxt) > MAX_WIDTH) w_nxt = 11'(MAX_WIDTH);
    h_nxt = cfg.image_height;
    if (h_nxt == '0) h_nxt = 11'd1;
    else if (32'(h_nxt) > MAX_HEIGHT) h_nxt = 11'(MAX_HEIGHT);
    lim_nxt = (cfg.iteration_limit < MIN_LIMIT) ? MIN_LIMIT : cfg.iteration_limit;
  end

  // Shared divider: default step 4/width, or palette position i/limit
  assign div_dividend = cmd.div_pal ? (DIV_W'(iter_r) << 16) : FOUR_FIX;
  assign div_divisor  = cmd.div_pal ? lim_r : 16'(w_r);

  mbet_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Pixel offsets from the frame center, times the step
  assign offr      = $signed({2'b00, col_r, 1'b0}) - $signed({2'b00, w_r});
  assign offi      = $signed({2'b00, row_r, 1'b0}) - $signed({2'b00, h_r});
  assign step_s    = $signed({1'b0, step_r});
  assign prodr_nxt = offr * step_s;
  assign prodi_nxt = offi * step_s;
  assign pidx_full = 21'(row_r) * 21'(w_r) + 21'(col_r);

  // z products and update
  assign rr_nxt = zr_r * zr_r;
  assign ii_nxt = zi_r * zi_r;
  assign ri_nxt = zr_r * zi_r;
  assign mag    = 65'($unsigned(rr_r)) + 65'($unsigned(ii_r));
  assign diff   = rr_r - ii_r;
  assign zr_nxt = sat32(65'(diff >>> FRAC_BITS) + 65'(cr_r));
  assign zi_nxt = sat32(65'(ri_r >>> (FRAC_BITS - 1)) + 65'(ci_r));

  // Palette from m and m^3
  assign red_t   = 40'(m3_r[47:16]) * 40'(RED_GAIN);
  assign green_t = 24'(m_r) * 24'(GREEN_GAIN);
  assign blue_m  = 17'h1_0000 - 17'(m_r);
  assign blue_t  = 25'(blue_m) * 25'(BLUE_GAIN);
  assign red_v   = RED_BASE + red_t[39:32];
  assign green_v = GREEN_BASE + green_t[23:16];
  assign blue_v  = BLUE_BASE + blue_t[23:16];

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      col_r  <= in_column;
      row_r  <= in_row;
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      lim_r  <= lim_nxt;
      step_r <= cfg.pixel_step;
    end
    if (cmd.step_load) begin
      step_r <= (div_q > DIV_W'(STEP_MAX)) ? STEP_MAX : div_q[30:0];
    end
    if (cmd.coord_mul) begin
      prodr_r <= prodr_nxt;
      prodi_r <= prodi_nxt;
      pidx_r  <= pidx_full[19:0];
    end
    if (cmd.coord_add) begin
      cr_r   <= sat32(65'(cfg.center_real) + 65'(prodr_r >>> 1));
      ci_r   <= sat32(65'(cfg.center_imag) + 65'(prodi_r >>> 1));
      zr_r   <= '0;
      zi_r   <= '0;
      iter_r <= '0;
    end
    if (cmd.iter_mul) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      ri_r <= ri_nxt;
    end
    if (cmd.iter_upd) begin
      zr_r   <= zr_nxt;
      zi_r   <= zi_nxt;
      iter_r <= iter_r + 1'b1;
    end
    if (cmd.m_load) m_r <= div_q[15:0];
    if (cmd.pal_sq) mm_r <= 32'(m_r) * 32'(m_r);
    if (cmd.pal_cube) m3_r <= 48'(mm_r) * 48'(m_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_write) begin
      red_r     <= cmd.out_inside ? IN_RED : red_v;
      green_r   <= cmd.out_inside ? IN_GREEN : green_v;
      blue_r    <= cmd.out_inside ? IN_BLUE : blue_v;
      cnt_r     <= iter_r;
      inside_r  <= cmd.out_inside;
      pix_out_r <= pidx_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.red             = red_r;
  assign out_ch.green           = green_r;
  assign out_ch.blue            = blue_r;
  assign out_ch.alpha           = ALPHA_FULL;
  assign out_ch.iteration_count = cnt_r;
  assign out_ch.inside_set      = inside_r;
  assign out_ch.pixel_index     = pix_out_r;

  // Status to the controller
  assign sts.step_zero = (step_r == '0);
  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.escape    = ((mag >> FRAC_BITS) > FOUR_CMP);
  assign sts.last_iter = (17'(iter_r) + 17'd1 == 17'(lim_r));
  assign sts.out_full  = out_valid_r && !out_ch.ready;

endmodule

FILE: hw/rtl/mbet_ctrl.sv
// Sequencer for the escape-time pixel: drives datapath commands per state.
// Depends on mbet_pkg, mbet_in_if and the assertion macro header.
`include "mandelbrot_escape_time_pixel_defines.svh"
module mbet_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  mbet_in_if.sink             in_ch,
  input  mbet_pkg::mbet_sts_t sts,
  output mbet_pkg::mbet_cmd_t cmd
);
  import mbet_pkg::*;

  mbet_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.step_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_STEP_WAIT;
        end else begin
          state_nxt = ST_COORD_MUL;
        end
      end
      ST_STEP_WAIT: begin
        if (sts.div_done) begin
          cmd.step_load = 1'b1;
          state_nxt     = ST_COORD_MUL;
        end
      end
      ST_COORD_MUL: begin
        cmd.coord_mul = 1'b1;
        state_nxt     = ST_COORD_ADD;
      end
      ST_COORD_ADD: begin
        cmd.coord_add = 1'b1;
        state_nxt     = ST_ITER_MUL;
      end
      ST_ITER_MUL: begin
        cmd.iter_mul = 1'b1;
        state_nxt    = ST_ITER_UPD;
      end
      ST_ITER_UPD: begin
        if (sts.escape) begin
          state_nxt = ST_PAL_DIV;
        end else begin
          cmd.iter_upd = 1'b1;
          state_nxt    = sts.last_iter ? ST_OUT_IN : ST_ITER_MUL;
        end
      end
      ST_PAL_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_pal   = 1'b1;
        state_nxt     = ST_PAL_WAIT;
      end
      ST_PAL_WAIT: begin
        if (sts.div_done) begin
          cmd.m_load = 1'b1;
          state_nxt  = ST_PAL_SQ;
        end
      end
      ST_PAL_SQ: begin
        cmd.pal_sq = 1'b1;
        state_nxt  = ST_PAL_CUBE;
      end
      ST_PAL_CUBE: begin
        cmd.pal_cube = 1'b1;
        state_nxt    = ST_OUT_ESC;
      end
      ST_OUT_ESC: begin
        if (!sts.out_full) begin
          cmd.out_write = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_OUT_IN: begin
        if (!sts.out_full) begin
          cmd.out_write  = 1'b1;
          cmd.out_inside = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `MBET_ASSERT_IMPL(a_no_overwrite, cmd.out_write, !sts.out_full, "result beat overwritten")
  `MBET_ASSERT_IMPL(a_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `MBET_ASSERT_IMPL(a_div_expected, sts.div_done, (state_r == ST_STEP_WAIT || state_r == ST_PAL_WAIT), "unexpected divider done")
  `MBET_ASSERT_NEXT(a_limit_exit, (state_r == ST_ITER_UPD && !sts.escape && sts.last_iter), (state_r == ST_OUT_IN), "limit not honored")

endmodule

FILE: hw/rtl/mandelbrot_escape_time_pixel.sv
// Escape-time pixel colorer: one pixel at a time; each z iteration has a multiply
// state, then a test and update state. When pixel_step is zero the step is taken
// from the shared divider as 4/width. The next pixel is taken while a result waits
// in the output register. Sync active-low reset: controller idle, output beat
// dropped, configuration registers to their reset values.
module mandelbrot_escape_time_pixel (
  input  logic                        clk,
  input  logic                        rst_n,
  mbet_in_if.sink                     in_ch,
  mbet_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbet_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mbet_pkg::*;

  mbet_cfg_t cfg_r;
  mbet_cmd_t cmd;
  mbet_sts_t sts;
  mbet_reg_t reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = mbet_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= RST_WIDTH;
      cfg_r.image_height    <= RST_HEIGHT;
      cfg_r.center_real     <= '0;
      cfg_r.center_imag     <= '0;
      cfg_r.pixel_step      <= '0;
      cfg_r.iteration_limit <= RST_LIMIT;
    end else if (wr_en) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:  cfg_r.image_width     <= pwdata[10:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height    <= pwdata[10:0];
        REG_CENTER_REAL:  cfg_r.center_real     <= $signed(pwdata);
        REG_CENTER_IMAG:  cfg_r.center_imag     <= $signed(pwdata);
        REG_PIXEL_STEP:   cfg_r.pixel_step      <= pwdata[30:0];
        REG_ITER_LIMIT:   cfg_r.iteration_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = 32'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg_r.image_height);
      REG_CENTER_REAL:  prdata = cfg_r.center_real;
      REG_CENTER_IMAG:  prdata = cfg_r.center_imag;
      REG_PIXEL_STEP:   prdata = 32'(cfg_r.pixel_step);
      REG_ITER_LIMIT:   prdata = 32'(cfg_r.iteration_limit);
      default:          prdata = '0;
    endcase
  end

  mbet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .cmd   (cmd)
  );

  mbet_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_column (in_ch.column),
    .in_row    (in_ch.row),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule
